@@ rtl/core/bbfq_pkg.sv @@
// Shared types and constants for the bounded byte FIFO queue.
package bbfq_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 8;
  localparam int CNT_W     = 8;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;

  localparam logic [CNT_W-1:0]  CAP_RESET = 8'd100;
  localparam logic [DATA_W-1:0] FILL_CHAR = 8'h30;  // ASCII '0'

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_PEEK  = 3'd1,
    OP_POP   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_FILL  = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

@@ rtl/core/bounded_byte_fifo_queue.sv @@
// Top level of the bounded byte FIFO queue: pointers, counters and result register.
//
// Bounded byte FIFO queue. A command (in_func, in_push_value) is taken on
// any clock edge with start high and busy low; busy never rises, so one
// command is taken per cycle. Every command yields exactly one result word,
// shown on the out_ ports for the single cycle in which out_valid is high,
// which is the cycle right after the command was taken. The receiver cannot
// stall this port and must take every word as it appears. Result timing
// follows the byte store, a RAM with a registered read port: the
// head entry is read in the command cycle and the RAM output register feeds
// out_read_byte directly. Commands: push, peek, pop, clear, fill-zeros.
// Fill-zeros marks all bytes held at that moment to read as '0' (0x30) by
// loading a counter, without touching the store. cfg_data sets the
// capacity (reset 100, clipped at DEPTH, 0 makes every push report full);
// write it only while no command is in flight. The store is not cleared at
// reset; only bytes written by push are ever read.
module bounded_byte_fifo_queue #(
  parameter int DEPTH = bbfq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [bbfq_pkg::FUNC_W-1:0]  in_func,
  input  logic [bbfq_pkg::DATA_W-1:0]  in_push_value,
  // result channel
  output logic                         out_valid,
  output logic [bbfq_pkg::STAT_W-1:0]  out_status,
  output logic [bbfq_pkg::DATA_W-1:0]  out_read_byte,
  output logic [bbfq_pkg::CNT_W-1:0]   out_occupancy,
  output logic                         out_is_empty_flag,
  // capacity register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bbfq_pkg::CNT_W-1:0]   cfg_data
);

  localparam int AW = $clog2(DEPTH);
  // The count register can never pass 255, so clip DEPTH to that range.
  localparam int DEPTH_CLIP = (DEPTH > 255) ? 255 : DEPTH;
  localparam logic [bbfq_pkg::CNT_W-1:0] DEPTH_CNT = bbfq_pkg::CNT_W'(DEPTH_CLIP);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic accept;

  // pointer / counter state
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [bbfq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [bbfq_pkg::CNT_W-1:0] filled_r, filled_nxt;
  logic [bbfq_pkg::CNT_W-1:0] cap_r;
  logic [bbfq_pkg::CNT_W-1:0] eff_cap;

  // result register
  logic                          out_valid_r;
  bbfq_pkg::status_t             status_r, status_nxt;
  logic [bbfq_pkg::DATA_W-1:0]   rd_r, rd_nxt;
  logic                          use_ram_r, use_ram_nxt;
  logic [bbfq_pkg::CNT_W-1:0]    occ_r;
  logic                          empty_r;

  // RAM port
  logic                        ram_we;
  logic                        ram_re;
  logic [bbfq_pkg::DATA_W-1:0] ram_rdata;

  // Nothing here ever stalls a command.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  assign eff_cap = (cap_r > DEPTH_CNT) ? DEPTH_CNT : cap_r;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  // Command decode: next pointers, counters and the result fields.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    filled_nxt  = filled_r;
    status_nxt  = bbfq_pkg::ST_OK;
    rd_nxt      = '0;
    use_ram_nxt = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (accept) begin
      case (bbfq_pkg::func_t'(in_func))
        bbfq_pkg::OP_PUSH: begin
          if (cnt_r >= eff_cap) begin
            status_nxt = bbfq_pkg::ST_FULL;
          end else begin
            ram_we   = 1'b1;
            tail_nxt = next_idx(tail_r);
            cnt_nxt  = cnt_r + 8'd1;
          end
        end
        bbfq_pkg::OP_PEEK, bbfq_pkg::OP_POP: begin
          if (cnt_r == '0) begin
            status_nxt = bbfq_pkg::ST_EMPTY;
          end else begin
            // filled entries are always the oldest ones
            if (filled_r != '0) begin
              rd_nxt = bbfq_pkg::FILL_CHAR;
            end else begin
              ram_re      = 1'b1;
              use_ram_nxt = 1'b1;
            end
            if (bbfq_pkg::func_t'(in_func) == bbfq_pkg::OP_POP) begin
              if (filled_r != '0) begin
                filled_nxt = filled_r - 8'd1;
              end
              head_nxt = next_idx(head_r);
              cnt_nxt  = cnt_r - 8'd1;
            end
          end
        end
        bbfq_pkg::OP_CLEAR: begin
          head_nxt   = '0;
          tail_nxt   = '0;
          cnt_nxt    = '0;
          filled_nxt = '0;
        end
        bbfq_pkg::OP_FILL: begin
          filled_nxt = cnt_r;
        end
        default: begin
          // unused codes: no-op, report current occupancy
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      filled_r    <= '0;
      cap_r       <= bbfq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= accept;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Result payload; only loaded for a taken command.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      rd_r      <= rd_nxt;
      use_ram_r <= use_ram_nxt;
      occ_r     <= cnt_nxt;
      empty_r   <= (cnt_nxt == '0);
    end
  end

  bbfq_ram #(
    .WIDTH (bbfq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_push_value),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // RAM output register lines up with the result register.
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_read_byte     = use_ram_r ? ram_rdata : rd_r;
  assign out_occupancy     = occ_r;
  assign out_is_empty_flag = empty_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("entry count exceeds store depth");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= cnt_r)
    else $error("filled counter exceeds entry count");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("taken command produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without a command");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == bbfq_pkg::OP_CLEAR))
      |=> (cnt_r == '0 && filled_r == '0 && head_r == '0 && tail_r == '0))
    else $error("clear left state behind");
`endif

endmodule

@@ rtl/core/bbfq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bbfq_ram #(
  parameter int WIDTH = bbfq_pkg::DATA_W,
  parameter int DEPTH = bbfq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
